>>> design/wapt_pkg.sv
// Package for the washer agitation phase timer.
// Holds command, phase and drive codes, timing constants and the PWM step.
// No dependencies.
`default_nettype none

package wapt_pkg;

    localparam logic [1:0] CMD_MOTOR_TICK  = 2'd0;
    localparam logic [1:0] CMD_SECOND_TICK = 2'd1;
    localparam logic [1:0] CMD_START       = 2'd2;
    localparam logic [1:0] CMD_BUTTON      = 2'd3;

    localparam logic [1:0] PH_WASH  = 2'd0;
    localparam logic [1:0] PH_RINSE = 2'd1;
    localparam logic [1:0] PH_SPIN  = 2'd2;
    localparam logic [1:0] PH_IDLE  = 2'd3;

    localparam logic [1:0] DRV_FWD  = 2'd0;
    localparam logic [1:0] DRV_STOP = 2'd1;
    localparam logic [1:0] DRV_REV  = 2'd2;

    localparam logic CFG_AGITATE_DUTY = 1'b0;
    localparam logic CFG_SPIN_DUTY    = 1'b1;

    localparam logic [6:0] AGITATE_DUTY_RESET = 7'd15;
    localparam logic [6:0] SPIN_DUTY_RESET    = 7'd40;

    localparam logic [4:0]  PRESCALE_TICKS = 5'd20;
    localparam logic [15:0] FWD_END        = 16'd16000;
    localparam logic [15:0] STOP_END       = 16'd20000;
    localparam logic [15:0] CYCLE_END      = 16'd36000;
    localparam logic [6:0]  PWM_PERIOD     = 7'd100;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // ceil(2^21 / 60): exact quotient for every 16-bit value after >> 21
    localparam logic [15:0] RECIP_60   = 16'd34953;
    localparam int          RECIP_SHIFT = 21;

    typedef struct packed {
        logic [6:0] cnt;
        logic [1:0] drive;
    } pwm_t;

    function automatic pwm_t pwm_step(input logic [6:0] cnt, input logic [6:0] duty,
                                      input logic [1:0] on_drive);
        pwm_t       r;
        logic [6:0] n;
        n       = cnt + 7'd1;
        r.drive = (n <= duty) ? on_drive : DRV_STOP;
        r.cnt   = (n == PWM_PERIOD) ? 7'd0 : n;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/washer_agitation_phase_timer.sv
// Washer agitation phase timer: phase countdown, pause/arm logic and motor PWM drive.
// Depends on wapt_pkg for codes, constants and the PWM step function.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    cmd, phase_kind, duration
// out      output     out_valid / out_ready  motor_drive, minutes_left, seconds_left,
//                                            phase_active, paused, armed
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle unless the output stalls; out_valid is set as it loads.
// The input register and the state/result registers form two stages; the state
// registers drive the result ports directly and update only when a result loads.
// A stalled output holds the state; the input register still takes one more request.
// Reset clears all state to idle, duties to their defaults; cfg_ready is always high.
`default_nettype none

module washer_agitation_phase_timer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  phase_kind,
    input  wire logic [15:0] duration,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       motor_drive,
    output logic [10:0]      minutes_left,
    output logic [5:0]       seconds_left,
    output logic             phase_active,
    output logic             paused,
    output logic             armed,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  kind_reg;
    logic [15:0] dur_reg;
    logic        out_valid_reg;
    logic        advance;

    logic [6:0]  agitate_duty_reg;
    logic [6:0]  spin_duty_reg;

    logic [4:0]  tick_prescale_reg, tick_prescale_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] target_reg, target_next;
    logic [10:0] minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [1:0]  phase_reg, phase_next;
    logic        run_reg, run_next;
    logic        pause_reg, pause_next;
    logic        sec_en_reg, sec_en_next;
    logic        motor_en_reg, motor_en_next;
    logic [1:0]  motor_state_reg, motor_state_next;
    logic [15:0] cycle_reg, cycle_next;
    logic [6:0]  fwd_cnt_reg, fwd_cnt_next;
    logic [6:0]  rev_cnt_reg, rev_cnt_next;
    logic [6:0]  spin_cnt_reg, spin_cnt_next;

    logic [31:0] recip_prod;
    logic [10:0] dur_min;
    logic [16:0] dur_min_x60;
    logic [16:0] dur_rem;

    wapt_pkg::pwm_t pwm_fwd;
    wapt_pkg::pwm_t pwm_rev;
    wapt_pkg::pwm_t pwm_spin;
    logic [15:0]    cycle_inc;
    logic [4:0]     prescale_inc;
    logic [15:0]    elapsed_inc;
    logic [5:0]     sec_base;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            kind_reg <= phase_kind;
            dur_reg  <= duration;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agitate_duty_reg <= wapt_pkg::AGITATE_DUTY_RESET;
            spin_duty_reg    <= wapt_pkg::SPIN_DUTY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == wapt_pkg::CFG_AGITATE_DUTY)
            begin
                agitate_duty_reg <= cfg_data;
            end
            else
            begin
                spin_duty_reg <= cfg_data;
            end
        end
    end

    // minutes and seconds of the requested duration
    assign recip_prod  = 32'(dur_reg) * 32'(wapt_pkg::RECIP_60);
    assign dur_min     = recip_prod[wapt_pkg::RECIP_SHIFT +: 11];
    assign dur_min_x60 = {dur_min, 6'd0} - {4'd0, dur_min, 2'd0};
    assign dur_rem     = {1'b0, dur_reg} - dur_min_x60;

    assign pwm_fwd      = wapt_pkg::pwm_step(fwd_cnt_reg, agitate_duty_reg, wapt_pkg::DRV_FWD);
    assign pwm_rev      = wapt_pkg::pwm_step(rev_cnt_reg, agitate_duty_reg, wapt_pkg::DRV_REV);
    assign pwm_spin     = wapt_pkg::pwm_step(spin_cnt_reg, spin_duty_reg, wapt_pkg::DRV_FWD);
    assign cycle_inc    = cycle_reg + 16'd1;
    assign prescale_inc = tick_prescale_reg + 5'd1;
    assign elapsed_inc  = elapsed_reg + 16'd1;
    assign sec_base     = (seconds_reg == 6'd0) ? wapt_pkg::SECS_PER_MIN : seconds_reg;

    always_comb
    begin
        tick_prescale_next = tick_prescale_reg;
        elapsed_next       = elapsed_reg;
        target_next        = target_reg;
        minutes_next       = minutes_reg;
        seconds_next       = seconds_reg;
        phase_next         = phase_reg;
        run_next           = run_reg;
        pause_next         = pause_reg;
        sec_en_next        = sec_en_reg;
        motor_en_next      = motor_en_reg;
        motor_state_next   = motor_state_reg;
        cycle_next         = cycle_reg;
        fwd_cnt_next       = fwd_cnt_reg;
        rev_cnt_next       = rev_cnt_reg;
        spin_cnt_next      = spin_cnt_reg;

        case (cmd_reg)
            wapt_pkg::CMD_MOTOR_TICK:
            begin
                if (motor_en_reg)
                begin
                    if (phase_reg == wapt_pkg::PH_WASH || phase_reg == wapt_pkg::PH_RINSE)
                    begin
                        cycle_next = cycle_inc;
                        if (cycle_inc < wapt_pkg::FWD_END)
                        begin
                            fwd_cnt_next     = pwm_fwd.cnt;
                            motor_state_next = pwm_fwd.drive;
                        end
                        else if (cycle_inc < wapt_pkg::STOP_END)
                        begin
                            motor_state_next = wapt_pkg::DRV_STOP;
                        end
                        else if (cycle_inc < wapt_pkg::CYCLE_END)
                        begin
                            rev_cnt_next     = pwm_rev.cnt;
                            motor_state_next = pwm_rev.drive;
                        end
                        else
                        begin
                            cycle_next = 16'd0;
                        end
                    end
                    else if (phase_reg == wapt_pkg::PH_SPIN)
                    begin
                        spin_cnt_next    = pwm_spin.cnt;
                        motor_state_next = pwm_spin.drive;
                    end
                end
            end
            wapt_pkg::CMD_SECOND_TICK:
            begin
                if (sec_en_reg)
                begin
                    tick_prescale_next = prescale_inc;
                    if (prescale_inc == wapt_pkg::PRESCALE_TICKS)
                    begin
                        tick_prescale_next = 5'd0;
                        if (elapsed_inc == target_reg)
                        begin
                            elapsed_next     = 16'd0;
                            phase_next       = wapt_pkg::PH_IDLE;
                            motor_state_next = wapt_pkg::DRV_STOP;
                            motor_en_next    = 1'b0;
                            sec_en_next      = 1'b0;
                        end
                        else
                        begin
                            elapsed_next  = elapsed_inc;
                            motor_en_next = 1'b1;
                            seconds_next  = sec_base - 6'd1;
                            if (seconds_reg == 6'd0 && minutes_reg != 11'd0)
                            begin
                                minutes_next = minutes_reg - 11'd1;
                            end
                        end
                    end
                end
            end
            wapt_pkg::CMD_START:
            begin
                if (kind_reg != wapt_pkg::PH_IDLE)
                begin
                    phase_next   = kind_reg;
                    target_next  = dur_reg;
                    elapsed_next = 16'd0;
                    minutes_next = dur_min;
                    seconds_next = dur_rem[5:0];
                    sec_en_next  = 1'b1;
                    pause_next   = 1'b0;
                end
            end
            wapt_pkg::CMD_BUTTON:
            begin
                if (!run_reg)
                begin
                    run_next = 1'b1;
                end
                else if (phase_reg != wapt_pkg::PH_IDLE)
                begin
                    pause_next    = !pause_reg;
                    sec_en_next   = pause_reg;
                    motor_en_next = pause_reg;
                    if (!pause_reg)
                    begin
                        motor_state_next = wapt_pkg::DRV_STOP;
                    end
                end
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_prescale_reg <= 5'd0;
            elapsed_reg       <= 16'd0;
            target_reg        <= 16'd0;
            minutes_reg       <= 11'd0;
            seconds_reg       <= 6'd0;
            phase_reg         <= wapt_pkg::PH_IDLE;
            run_reg           <= 1'b0;
            pause_reg         <= 1'b0;
            sec_en_reg        <= 1'b0;
            motor_en_reg      <= 1'b0;
            motor_state_reg   <= wapt_pkg::DRV_FWD;
            cycle_reg         <= 16'd0;
            fwd_cnt_reg       <= 7'd0;
            rev_cnt_reg       <= 7'd0;
            spin_cnt_reg      <= 7'd0;
        end
        else if (advance)
        begin
            tick_prescale_reg <= tick_prescale_next;
            elapsed_reg       <= elapsed_next;
            target_reg        <= target_next;
            minutes_reg       <= minutes_next;
            seconds_reg       <= seconds_next;
            phase_reg         <= phase_next;
            run_reg           <= run_next;
            pause_reg         <= pause_next;
            sec_en_reg        <= sec_en_next;
            motor_en_reg      <= motor_en_next;
            motor_state_reg   <= motor_state_next;
            cycle_reg         <= cycle_next;
            fwd_cnt_reg       <= fwd_cnt_next;
            rev_cnt_reg       <= rev_cnt_next;
            spin_cnt_reg      <= spin_cnt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign motor_drive  = motor_state_reg;
    assign minutes_left = minutes_reg;
    assign seconds_left = seconds_reg;
    assign phase_active = (phase_reg != wapt_pkg::PH_IDLE);
    assign paused       = pause_reg;
    assign armed        = run_reg;

`ifndef SYNTHESIS
    a_idle_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wapt_pkg::PH_IDLE) |-> !motor_en_reg)
        else $error("motor enabled with no phase");

    a_pause_stops_all: assert property (@(posedge clk) disable iff (!rst_n)
        pause_reg |-> (!sec_en_reg && !motor_en_reg && phase_reg != wapt_pkg::PH_IDLE))
        else $error("pause with counting enabled or no phase");

    a_seconds_range: assert property (@(posedge clk) disable iff (!rst_n)
        seconds_reg < wapt_pkg::SECS_PER_MIN)
        else $error("seconds out of range");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(minutes_reg) && $stable(motor_state_reg)
                                           && $stable(phase_reg)))
        else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire

>>> tb/sv/washer_agitation_phase_timer_tb.sv
// Testbench for washer_agitation_phase_timer: directed and random requests with a
// request-level predictor of the countdown, pause logic and motor drive.
// Depends on wapt_pkg for command, phase, drive and register codes.
module washer_agitation_phase_timer_tb;

    localparam int TICKS_PER_SECOND     = 20;
    localparam int FORWARD_TICKS        = 16000;
    localparam int HALT_TICKS           = 20000;
    localparam int AGITATE_TICKS        = 36000;
    localparam int AGITATE_SAMPLE_TICKS = 200;
    localparam int PWM_STEPS            = 100;
    localparam int SECONDS_PER_MINUTE   = 60;
    localparam int DEFAULT_AGITATE      = 15;
    localparam int DEFAULT_SPIN         = 40;
    localparam int HOLD_CYCLES          = 80;
    localparam int SETTLE_CYCLES        = 4;
    localparam int RANDOM_SESSION_ITEMS = 480;
    localparam int CYCLE_LIMIT          = 500000;

    typedef struct packed {
        logic [1:0]  drive;
        logic [10:0] minutes;
        logic [5:0]  seconds;
        logic        active;
        logic        paused;
        logic        armed;
    } panel_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [1:0]  phase_kind;
    logic [15:0] duration;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  motor_drive;
    logic [10:0] minutes_left;
    logic [5:0]  seconds_left;
    logic        phase_active;
    logic        paused;
    logic        armed;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    logic [6:0]  duty_agitate;
    logic [6:0]  duty_spin;
    logic [4:0]  tick_div;
    logic [15:0] secs_done;
    logic [15:0] secs_goal;
    logic [10:0] mins_shown;
    logic [5:0]  secs_shown;
    logic [1:0]  cur_phase;
    logic        is_armed;
    logic        is_paused;
    logic        count_on;
    logic        drive_on;
    logic [1:0]  cur_drive;
    logic [15:0] cycle_pos;
    logic [6:0]  fwd_pwm;
    logic [6:0]  rev_pwm;
    logic [6:0]  spin_pwm;
    logic        last_took_effect;

    panel_t      panel_expected[$];

    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_start;
    int          hold_left;
    int          cycle_count;
    int          requests_sent;
    int          effective_count;
    int          results_checked;
    int          phase_ends;
    int          reverse_seen;
    int          mismatches;

    washer_agitation_phase_timer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .phase_kind   (phase_kind),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motor_drive  (motor_drive),
        .minutes_left (minutes_left),
        .seconds_left (seconds_left),
        .phase_active (phase_active),
        .paused       (paused),
        .armed        (armed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("washer_agitation_phase_timer regression: fail");
            $finish;
        end
    end

    initial hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
            hold_start <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        panel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (panel_expected.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches = mismatches + 1;
            end
            else
            begin
                want = panel_expected.pop_front();
                check_field("motor_drive", 16'(want.drive), 16'(motor_drive));
                check_field("minutes_left", 16'(want.minutes), 16'(minutes_left));
                check_field("seconds_left", 16'(want.seconds), 16'(seconds_left));
                check_field("phase_active", 16'(want.active), 16'(phase_active));
                check_field("paused", 16'(want.paused), 16'(paused));
                check_field("armed", 16'(want.armed), 16'(armed));
                results_checked = results_checked + 1;
                if (motor_drive == wapt_pkg::DRV_REV)
                    reverse_seen = reverse_seen + 1;
            end
        end
    end

    task automatic clear_washer_state;
        duty_agitate = 7'(DEFAULT_AGITATE);
        duty_spin    = 7'(DEFAULT_SPIN);
        tick_div     = '0;
        secs_done    = '0;
        secs_goal    = '0;
        mins_shown   = '0;
        secs_shown   = '0;
        cur_phase    = wapt_pkg::PH_IDLE;
        is_armed     = 1'b0;
        is_paused    = 1'b0;
        count_on     = 1'b0;
        drive_on     = 1'b0;
        cur_drive    = wapt_pkg::DRV_FWD;
        cycle_pos    = '0;
        fwd_pwm      = '0;
        rev_pwm      = '0;
        spin_pwm     = '0;
    endtask

    task automatic pwm_advance(inout logic [6:0] cnt, input logic [6:0] duty,
                               input logic [1:0] on_drive, output logic [1:0] drv);
        cnt = cnt + 7'd1;
        drv = (cnt <= duty) ? on_drive : wapt_pkg::DRV_STOP;
        if (cnt == PWM_STEPS)
            cnt = 7'd0;
    endtask

    task automatic advance_washer(input logic [1:0] c, input logic [1:0] k,
                                  input logic [15:0] d, output panel_t p);
        last_took_effect = 1'b0;
        case (c)
            wapt_pkg::CMD_MOTOR_TICK:
            begin
                if (drive_on)
                begin
                    last_took_effect = 1'b1;
                    if (cur_phase == wapt_pkg::PH_WASH || cur_phase == wapt_pkg::PH_RINSE)
                    begin
                        cycle_pos = cycle_pos + 16'd1;
                        if (cycle_pos < FORWARD_TICKS)
                            pwm_advance(fwd_pwm, duty_agitate, wapt_pkg::DRV_FWD, cur_drive);
                        else if (cycle_pos < HALT_TICKS)
                            cur_drive = wapt_pkg::DRV_STOP;
                        else if (cycle_pos < AGITATE_TICKS)
                            pwm_advance(rev_pwm, duty_agitate, wapt_pkg::DRV_REV, cur_drive);
                        else
                            cycle_pos = '0;
                    end
                    else if (cur_phase == wapt_pkg::PH_SPIN)
                    begin
                        pwm_advance(spin_pwm, duty_spin, wapt_pkg::DRV_FWD, cur_drive);
                    end
                end
            end
            wapt_pkg::CMD_SECOND_TICK:
            begin
                if (count_on)
                begin
                    last_took_effect = 1'b1;
                    tick_div = tick_div + 5'd1;
                    if (tick_div == TICKS_PER_SECOND)
                    begin
                        tick_div  = '0;
                        secs_done = secs_done + 16'd1;
                        if (secs_done == secs_goal)
                        begin
                            secs_done  = '0;
                            cur_phase  = wapt_pkg::PH_IDLE;
                            cur_drive  = wapt_pkg::DRV_STOP;
                            drive_on   = 1'b0;
                            count_on   = 1'b0;
                            phase_ends = phase_ends + 1;
                        end
                        else
                        begin
                            drive_on = 1'b1;
                            if (secs_shown == 6'd0)
                            begin
                                secs_shown = 6'(SECONDS_PER_MINUTE);
                                if (mins_shown != 11'd0)
                                    mins_shown = mins_shown - 11'd1;
                            end
                            secs_shown = secs_shown - 6'd1;
                        end
                    end
                end
            end
            wapt_pkg::CMD_START:
            begin
                if (k != wapt_pkg::PH_IDLE)
                begin
                    last_took_effect = 1'b1;
                    cur_phase  = k;
                    secs_goal  = d;
                    secs_done  = '0;
                    mins_shown = 11'(d / SECONDS_PER_MINUTE);
                    secs_shown = 6'(d % SECONDS_PER_MINUTE);
                    count_on   = 1'b1;
                    is_paused  = 1'b0;
                end
            end
            wapt_pkg::CMD_BUTTON:
            begin
                if (!is_armed)
                begin
                    last_took_effect = 1'b1;
                    is_armed = 1'b1;
                end
                else if (cur_phase != wapt_pkg::PH_IDLE)
                begin
                    last_took_effect = 1'b1;
                    is_paused = !is_paused;
                    count_on  = !is_paused;
                    drive_on  = !is_paused;
                    if (is_paused)
                        cur_drive = wapt_pkg::DRV_STOP;
                end
            end
        endcase
        p.drive   = cur_drive;
        p.minutes = mins_shown;
        p.seconds = secs_shown;
        p.active  = (cur_phase != wapt_pkg::PH_IDLE);
        p.paused  = is_paused;
        p.armed   = is_armed;
    endtask

    task automatic send_request(input logic [1:0] c, input logic [1:0] k,
                                input logic [15:0] d);
        panel_t want;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        phase_kind <= k;
        duration   <= d;
        do
            @(posedge clk);
        while (!in_ready);
        advance_washer(c, k, d, want);
        panel_expected.push_back(want);
        requests_sent = requests_sent + 1;
        if (last_took_effect)
            effective_count = effective_count + 1;
    endtask

    task automatic wait_results_drained;
        in_valid <= 1'b0;
        while (panel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == wapt_pkg::CFG_AGITATE_DUTY)
            duty_agitate = value;
        else
            duty_spin = value;
    endtask

    task automatic send_ticks(input logic [1:0] c, input int count);
        repeat (count) send_request(c, 2'($urandom), 16'($urandom));
    endtask

    task automatic test_arm_and_ignore;
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_SPIN, 16'd5);
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_IDLE, 16'd77);
        send_request(wapt_pkg::CMD_SECOND_TICK, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_MOTOR_TICK, wapt_pkg::PH_WASH, 16'd0);
    endtask

    task automatic test_minutes_at_zero;
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_WASH, 16'd0);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, TICKS_PER_SECOND);
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_RINSE, 16'd60);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, TICKS_PER_SECOND);
    endtask

    task automatic test_pause_in_rinse;
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_MOTOR_TICK, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_SECOND_TICK, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_WASH, 16'd0);
        send_ticks(wapt_pkg::CMD_MOTOR_TICK, 3);
    endtask

    task automatic test_phase_end;
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_SPIN, 16'd1);
        send_request(wapt_pkg::CMD_MOTOR_TICK, wapt_pkg::PH_WASH, 16'd0);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, TICKS_PER_SECOND);
        send_request(wapt_pkg::CMD_MOTOR_TICK, wapt_pkg::PH_WASH, 16'd0);
        send_request(wapt_pkg::CMD_BUTTON, wapt_pkg::PH_WASH, 16'd0);
    endtask

    task automatic test_duration_extremes;
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_WASH, 16'hFFFF);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, TICKS_PER_SECOND);
        send_ticks(wapt_pkg::CMD_MOTOR_TICK, 2);
    endtask

    task automatic test_backpressure;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        wait_results_drained();
        hold_start <= 1'b1;
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_SPIN, 16'd3);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, 21);
        send_ticks(wapt_pkg::CMD_MOTOR_TICK, 6);
        wait_results_drained();
    endtask

    task automatic test_agitation_cycle;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        write_reg(wapt_pkg::CFG_AGITATE_DUTY, 7'($urandom_range(1, 99)));
        write_reg(wapt_pkg::CFG_SPIN_DUTY, 7'd100);
        send_request(wapt_pkg::CMD_START, wapt_pkg::PH_WASH, 16'hFFFF);
        send_ticks(wapt_pkg::CMD_SECOND_TICK, TICKS_PER_SECOND);
        send_ticks(wapt_pkg::CMD_MOTOR_TICK, AGITATE_SAMPLE_TICKS);
        wait_results_drained();
    endtask

    task automatic run_random_session(input int target);
        int          goal;
        int          pick;
        logic [15:0] d;
        goal = requests_sent + target;
        while (requests_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_request(2'($urandom), 2'($urandom), 16'($urandom));
            end
            else if (pick < 12)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    d = 16'($urandom_range(1, 4));
                else if (pick < 80)
                    d = 16'($urandom_range(55, 65));
                else if (pick < 90)
                    d = 16'($urandom);
                else if (pick < 95)
                    d = 16'd0;
                else
                    d = 16'hFFFF;
                send_request(wapt_pkg::CMD_START, 2'($urandom_range(0, 2)), d);
            end
            else if (pick < 18)
            begin
                send_request(wapt_pkg::CMD_BUTTON, 2'($urandom), 16'($urandom));
            end
            else if (pick < 45)
            begin
                send_ticks(wapt_pkg::CMD_MOTOR_TICK, $urandom_range(1, 30));
            end
            else
            begin
                send_ticks(wapt_pkg::CMD_SECOND_TICK, $urandom_range(1, 25));
            end
        end
    endtask

    task automatic test_random_traffic;
        write_reg(wapt_pkg::CFG_AGITATE_DUTY, 7'd0);
        write_reg(wapt_pkg::CFG_SPIN_DUTY, 7'd127);
        send_idle_pct  <= 17;
        recv_stall_pct <= 84;
        run_random_session(RANDOM_SESSION_ITEMS);
        write_reg(wapt_pkg::CFG_AGITATE_DUTY, 7'd100);
        write_reg(wapt_pkg::CFG_SPIN_DUTY, 7'd0);
        send_idle_pct  <= 84;
        recv_stall_pct <= 17;
        run_random_session(RANDOM_SESSION_ITEMS);
        write_reg(wapt_pkg::CFG_AGITATE_DUTY, 7'($urandom_range(0, 127)));
        write_reg(wapt_pkg::CFG_SPIN_DUTY, 7'($urandom_range(0, 100)));
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        run_random_session(RANDOM_SESSION_ITEMS);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        cmd            <= wapt_pkg::CMD_MOTOR_TICK;
        phase_kind     <= wapt_pkg::PH_WASH;
        duration       <= '0;
        out_ready      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= wapt_pkg::CFG_AGITATE_DUTY;
        cfg_data       <= '0;
        hold_start     <= 1'b0;
        send_idle_pct  <= 30;
        recv_stall_pct <= 30;
        requests_sent   = 0;
        effective_count = 0;
        results_checked = 0;
        phase_ends      = 0;
        reverse_seen    = 0;
        mismatches      = 0;
        clear_washer_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arm_and_ignore();
        test_minutes_at_zero();
        test_pause_in_rinse();
        test_phase_end();
        test_duration_extremes();
        test_backpressure();
        test_agitation_cycle();
        test_random_traffic();
        wait_results_drained();

        $display("covered %0d requests (%0d changed state), %0d results checked",
                 requests_sent, effective_count, results_checked);
        $display("%0d phase ends, %0d reverse-drive results, %0d mismatches",
                 phase_ends, reverse_seen, mismatches);
        if (mismatches == 0)
            $display("washer_agitation_phase_timer regression: pass");
        else
            $display("washer_agitation_phase_timer regression: fail");
        $finish;
    end

endmodule
